@@ hw/rtl/obm_pkg.sv @@
// ----------------------------------------------------------------------------
// obm_pkg
// Types and codes shared by the order book controller and datapath.
// ----------------------------------------------------------------------------
package obm_pkg;

  localparam logic [2:0] REQ_ADD     = 3'd0;
  localparam logic [2:0] REQ_CANCEL  = 3'd1;
  localparam logic [2:0] REQ_MODIFY  = 3'd2;
  localparam logic [2:0] REQ_EXECUTE = 3'd3;

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_BAD_QTY  = 4'd1;
  localparam logic [3:0] ST_BAD_PRC  = 4'd2;
  localparam logic [3:0] ST_DUP      = 4'd3;
  localparam logic [3:0] ST_UNKNOWN  = 4'd4;
  localparam logic [3:0] ST_EXCEEDS  = 4'd5;
  localparam logic [3:0] ST_UNSUPP   = 4'd6;
  localparam logic [3:0] ST_BAD_SIDE = 4'd7;
  localparam logic [3:0] ST_SYMBOL   = 4'd8;
  localparam logic [3:0] ST_OVERFLOW = 4'd9;
  localparam logic [3:0] ST_FULL     = 4'd10;

  localparam logic [3:0] OP_NONE       = 4'd0;
  localparam logic [3:0] OP_LOAD       = 4'd1;
  localparam logic [3:0] OP_SCAN       = 4'd2;
  localparam logic [3:0] OP_SCAN_OSIDE = 4'd3;
  localparam logic [3:0] OP_TRADE      = 4'd4;
  localparam logic [3:0] OP_INSERT     = 4'd5;
  localparam logic [3:0] OP_MOD_QTY    = 4'd6;
  localparam logic [3:0] OP_EXEC       = 4'd7;
  localparam logic [3:0] OP_CANCEL     = 4'd8;
  localparam logic [3:0] OP_REMOVE     = 4'd9;

  localparam logic [1:0] AMT_ZERO = 2'd0;
  localparam logic [1:0] AMT_QTY  = 2'd1;
  localparam logic [1:0] AMT_EXEC = 2'd2;

  typedef struct packed {
    logic [31:0]        id;
    logic               side;
    logic signed [31:0] price;
    logic [31:0]        qty;
    logic [31:0]        rank;
  } entry_t;

  typedef struct packed {
    logic [3:0] op;
    logic       emit;
    logic [3:0] code;
    logic [1:0] amt;
  } cmd_t;

  typedef struct packed {
    logic       busy;
    logic       sym_ok;
    logic [2:0] req;
    logic       side_bad;
    logic       qty_zero;
    logic       price_bad;
    logic       found;
    logic       ovf;
    logic       in_place;
    logic       exceeds;
    logic       crosses;
    logic       rem_zero;
    logic       free_ok;
    logic       out_free;
  } sts_t;

endpackage

@@ hw/rtl/obm_ctrl.sv @@
// ----------------------------------------------------------------------------
// obm_ctrl
// Sequencer for request checks, table scans, fills and status results.
// ----------------------------------------------------------------------------
module obm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  obm_pkg::sts_t sts,
  output obm_pkg::cmd_t cmd
);
  import obm_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_SCAN1  = 3'd2;
  localparam logic [2:0] S_SCAN2  = 3'd3;
  localparam logic [2:0] S_RESCAN = 3'd4;
  localparam logic [2:0] S_MATCH  = 3'd5;

  logic [2:0] state_r, state_nxt;
  cmd_t       c;

  always_comb begin
    state_nxt = state_r;
    c = '0;
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        c.op = OP_LOAD;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = S_IDLE;
        c.emit = 1'b1;
        if (!sts.sym_ok) c.code = ST_SYMBOL;
        else if (sts.req == REQ_ADD) begin
          if (sts.side_bad) c.code = ST_BAD_SIDE;
          else if (sts.qty_zero) c.code = ST_BAD_QTY;
          else if (sts.price_bad) c.code = ST_BAD_PRC;
          else begin
            c.emit = 1'b0;
            c.op = OP_SCAN;
            state_nxt = S_SCAN1;
          end
        end else if (sts.req == REQ_CANCEL || sts.req == REQ_MODIFY ||
                     sts.req == REQ_EXECUTE) begin
          c.emit = 1'b0;
          c.op = OP_SCAN;
          state_nxt = S_SCAN1;
        end else c.code = ST_UNSUPP;
      end
      S_SCAN1: if (!sts.busy) begin
        state_nxt = S_IDLE;
        c.emit = 1'b1;
        if (sts.req == REQ_ADD) begin
          if (sts.found) c.code = ST_DUP;
          else if (sts.ovf) c.code = ST_OVERFLOW;
          else begin
            c.emit = 1'b0;
            state_nxt = S_MATCH;
          end
        end else if (!sts.found) c.code = ST_UNKNOWN;
        else if (sts.req == REQ_CANCEL) begin
          c.op = OP_CANCEL;
          c.code = ST_OK;
        end else if (sts.req == REQ_EXECUTE) begin
          if (sts.qty_zero) c.code = ST_BAD_QTY;
          else if (sts.exceeds) c.code = ST_EXCEEDS;
          else begin
            c.op = OP_EXEC;
            c.code = ST_OK;
            c.amt = AMT_EXEC;
          end
        end else begin
          if (sts.price_bad) c.code = ST_BAD_PRC;
          else if (sts.qty_zero) c.code = ST_BAD_QTY;
          else begin
            c.emit = 1'b0;
            c.op = OP_SCAN_OSIDE;
            state_nxt = S_SCAN2;
          end
        end
      end
      S_SCAN2: if (!sts.busy) begin
        if (sts.ovf) begin
          c.emit = 1'b1;
          c.code = ST_OVERFLOW;
          state_nxt = S_IDLE;
        end else if (sts.in_place) begin
          c.op = OP_MOD_QTY;
          c.emit = 1'b1;
          c.code = ST_OK;
          c.amt = AMT_QTY;
          state_nxt = S_IDLE;
        end else begin
          c.op = OP_REMOVE;
          state_nxt = S_RESCAN;
        end
      end
      S_RESCAN: begin
        c.op = OP_SCAN;
        state_nxt = S_MATCH;
      end
      S_MATCH: if (!sts.busy) begin
        if (sts.crosses) begin
          c.op = OP_TRADE;
          state_nxt = S_RESCAN;
        end else begin
          c.emit = 1'b1;
          state_nxt = S_IDLE;
          if (sts.rem_zero) c.code = ST_OK;
          else if (!sts.free_ok) c.code = ST_FULL;
          else begin
            c.op = OP_INSERT;
            c.code = ST_OK;
            c.amt = AMT_QTY;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // hold until the output register can take the result
    if ((c.emit || c.op == OP_TRADE) && !sts.out_free) begin
      c = '0;
      state_nxt = state_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign cmd = c;
  assign in_stall = (state_r != S_IDLE);

endmodule

@@ hw/rtl/obm_dp.sv @@
// ----------------------------------------------------------------------------
// obm_dp
// Order table, scan unit, request registers, counters and result register.
// ----------------------------------------------------------------------------
module obm_dp #(
  parameter int MAX_ORDERS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_symbol_code,
  input  logic [2:0]         in_req_type,
  input  logic [15:0]        in_symbol,
  input  logic [63:0]        in_event_seq,
  input  logic [31:0]        in_order_id,
  input  logic [1:0]         in_side,
  input  logic signed [31:0] in_price,
  input  logic [31:0]        in_quantity,
  input  logic [63:0]        in_timestamp,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_kind,
  output logic [3:0]         out_status,
  output logic [63:0]        out_seq,
  output logic [15:0]        out_symbol,
  output logic [63:0]        out_trade_number,
  output logic [31:0]        out_aggressor_id,
  output logic [31:0]        out_resting_id,
  output logic signed [31:0] out_trade_price,
  output logic [31:0]        out_amount,
  output logic [63:0]        out_trade_time,
  output logic               out_last,
  input  obm_pkg::cmd_t      cmd,
  output obm_pkg::sts_t      sts
);
  import obm_pkg::*;

  localparam int IW = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
  localparam int CW = $clog2(MAX_ORDERS + 1);
  localparam int SW = 32 + CW;

  logic [15:0]        sym_code_r;
  logic [2:0]         req_r;
  logic [15:0]        sym_r;
  logic [63:0]        seq_r;
  logic [31:0]        id_r;
  logic               side_r;
  logic               side_bad_r;
  logic signed [31:0] price_r;
  logic [31:0]        qty_r;
  logic [63:0]        ts_r;
  logic [31:0]        arrival_r;
  logic [63:0]        tcnt_r;

  entry_t             mem [MAX_ORDERS];
  logic               valid_r [MAX_ORDERS];
  entry_t             rd_r;
  logic               pv_r;
  logic               p_ok_r;
  logic [IW-1:0]      p_idx_r;
  logic               scan_on_r;
  logic [CW-1:0]      cnt_r;

  logic               have_match_r, have_best_r, have_free_r;
  logic [IW-1:0]      match_idx_r, best_idx_r, free_idx_r;
  entry_t             match_e_r, best_e_r;
  logic [31:0]        best_age_r;
  logic [SW-1:0]      sum_r;

  logic               out_valid_r;
  logic               out_free;
  logic               scan_start;
  logic [31:0]        age;
  logic               cand, better;
  logic [31:0]        fill;
  logic [SW-1:0]      removed, sum_adj;
  logic [SW:0]        total;
  logic               wr_en;
  logic [IW-1:0]      wr_idx;
  entry_t             wr_data;

  assign scan_start = (cmd.op == OP_SCAN) || (cmd.op == OP_SCAN_OSIDE);
  assign out_free = !out_valid_r || !out_stall;
  assign fill = (qty_r < best_e_r.qty) ? qty_r : best_e_r.qty;

  // request registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) sym_code_r <= '0;
    else if (cfg_we) sym_code_r <= cfg_symbol_code;
    if (cmd.op == OP_LOAD) begin
      req_r      <= in_req_type;
      sym_r      <= in_symbol;
      seq_r      <= in_event_seq;
      id_r       <= in_order_id;
      side_r     <= in_side[0];
      side_bad_r <= in_side[1];
      price_r    <= in_price;
      qty_r      <= in_quantity;
      ts_r       <= in_timestamp;
    end else if (cmd.op == OP_SCAN_OSIDE || cmd.op == OP_REMOVE) begin
      side_r <= match_e_r.side;
    end else if (cmd.op == OP_TRADE) begin
      qty_r <= qty_r - fill;
    end
  end

  // table writes
  always_comb begin
    wr_en = 1'b0;
    wr_idx = best_idx_r;
    wr_data = best_e_r;
    unique case (cmd.op)
      OP_TRADE: begin
        wr_en = 1'b1;
        wr_data.qty = best_e_r.qty - fill;
      end
      OP_INSERT: begin
        wr_en = 1'b1;
        wr_idx = free_idx_r;
        wr_data = '{id: id_r, side: side_r, price: price_r, qty: qty_r, rank: arrival_r};
      end
      OP_MOD_QTY: begin
        wr_en = 1'b1;
        wr_idx = match_idx_r;
        wr_data = match_e_r;
        wr_data.qty = qty_r;
      end
      OP_EXEC: begin
        wr_en = 1'b1;
        wr_idx = match_idx_r;
        wr_data = match_e_r;
        wr_data.qty = match_e_r.qty - qty_r;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= wr_data;
    rd_r <= mem[cnt_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_ORDERS; i++) valid_r[i] <= 1'b0;
      arrival_r <= '0;
      tcnt_r <= 64'd1;
    end else begin
      unique case (cmd.op)
        OP_TRADE: begin
          if (best_e_r.qty == fill) valid_r[best_idx_r] <= 1'b0;
          tcnt_r <= tcnt_r + 64'd1;
        end
        OP_INSERT: begin
          valid_r[free_idx_r] <= 1'b1;
          arrival_r <= arrival_r + 32'd1;
        end
        OP_EXEC: if (match_e_r.qty == qty_r) valid_r[match_idx_r] <= 1'b0;
        OP_CANCEL, OP_REMOVE: valid_r[match_idx_r] <= 1'b0;
        default: ;
      endcase
    end
  end

  // scan: one entry issued per cycle, processed in the next cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_on_r <= 1'b0;
      p_ok_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      p_ok_r <= scan_on_r;
      if (scan_start) begin
        scan_on_r <= 1'b1;
        cnt_r <= '0;
      end else if (scan_on_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(MAX_ORDERS - 1)) scan_on_r <= 1'b0;
      end
    end
    p_idx_r <= cnt_r[IW-1:0];
    pv_r <= valid_r[cnt_r[IW-1:0]];
  end

  assign age  = arrival_r - rd_r.rank;
  assign cand = pv_r && (rd_r.side != side_r);
  always_comb begin
    if (!have_best_r) better = 1'b1;
    else if (rd_r.price != best_e_r.price)
      better = side_r ? (rd_r.price > best_e_r.price) : (rd_r.price < best_e_r.price);
    else better = age > best_age_r;
  end

  always_ff @(posedge clk) begin
    if (scan_start) begin
      have_match_r <= 1'b0;
      have_best_r <= 1'b0;
      have_free_r <= 1'b0;
      sum_r <= '0;
    end else if (p_ok_r) begin
      if (pv_r && rd_r.id == id_r) begin
        have_match_r <= 1'b1;
        match_idx_r <= p_idx_r;
        match_e_r <= rd_r;
      end
      if (pv_r && rd_r.side == side_r && rd_r.price == price_r)
        sum_r <= sum_r + SW'(rd_r.qty);
      if (cand && better) begin
        have_best_r <= 1'b1;
        best_idx_r <= p_idx_r;
        best_e_r <= rd_r;
        best_age_r <= age;
      end
      if (!pv_r && !have_free_r) begin
        have_free_r <= 1'b1;
        free_idx_r <= p_idx_r;
      end
    end
  end

  // level total with the order's own old quantity taken out
  assign removed = (have_match_r && price_r == match_e_r.price) ? SW'(match_e_r.qty) : '0;
  assign sum_adj = (sum_r >= removed) ? sum_r - removed : '0;
  assign total   = (SW + 1)'(qty_r) + (SW + 1)'(sum_adj);

  always_comb begin
    sts.busy      = scan_on_r || p_ok_r;
    sts.sym_ok    = (sym_r == sym_code_r);
    sts.req       = req_r;
    sts.side_bad  = side_bad_r;
    sts.qty_zero  = (qty_r == 32'd0);
    sts.price_bad = (price_r <= 0);
    sts.found     = have_match_r;
    sts.ovf       = (total[SW:32] != '0);
    sts.in_place  = (price_r == match_e_r.price) && (qty_r <= match_e_r.qty);
    sts.exceeds   = (qty_r > match_e_r.qty);
    sts.crosses   = have_best_r && (qty_r != 32'd0) &&
                    (side_r ? (price_r <= best_e_r.price) : (price_r >= best_e_r.price));
    sts.rem_zero  = (qty_r == 32'd0);
    sts.free_ok   = have_free_r;
    sts.out_free  = out_free;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.emit || cmd.op == OP_TRADE) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
    if (cmd.op == OP_TRADE) begin
      out_kind         <= 1'b0;
      out_status       <= ST_OK;
      out_trade_number <= tcnt_r;
      out_aggressor_id <= id_r;
      out_resting_id   <= best_e_r.id;
      out_trade_price  <= best_e_r.price;
      out_amount       <= fill;
      out_trade_time   <= ts_r;
      out_last         <= 1'b0;
      out_seq          <= seq_r;
      out_symbol       <= sym_r;
    end else if (cmd.emit) begin
      out_kind         <= 1'b1;
      out_status       <= cmd.code;
      out_trade_number <= '0;
      out_aggressor_id <= '0;
      out_resting_id   <= '0;
      out_trade_price  <= '0;
      out_trade_time   <= '0;
      out_last         <= 1'b1;
      out_seq          <= seq_r;
      out_symbol       <= sym_r;
      unique case (cmd.amt)
        AMT_QTY:  out_amount <= qty_r;
        AMT_EXEC: out_amount <= match_e_r.qty - qty_r;
        default:  out_amount <= '0;
      endcase
    end
  end

  assign out_valid = out_valid_r;

  a_trade_has_best: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_TRADE) |-> (have_best_r && fill != 32'd0))
    else $error("trade without a resting order");
  a_insert_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_INSERT) |-> (have_free_r && !valid_r[free_idx_r]))
    else $error("insert into an occupied entry");
  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit || cmd.op == OP_TRADE) |-> out_free)
    else $error("result written over a pending one");
  a_no_scan_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    scan_start |-> !(scan_on_r || p_ok_r))
    else $error("scan restarted while running");

endmodule

@@ hw/rtl/limit_order_book_matcher.sv @@
// ----------------------------------------------------------------------------
// limit_order_book_matcher
// Price-time priority matcher for one symbol over a table of resting orders.
// ----------------------------------------------------------------------------
// each table scan visits every entry, one entry per cycle
// a request rejected by the checks takes no scan; cancel and execute take one scan
// add: (fills + 1) scans
// modify: 2 scans in place, (fills + 3) scans resubmitted
// one request at a time; the next is taken while the last result waits
// synchronous reset empties the book at once and sets the trade counter to 1
module limit_order_book_matcher #(
  parameter int MAX_ORDERS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_symbol_code,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_req_type,
  input  logic [15:0]        in_symbol,
  input  logic [63:0]        in_event_seq,
  input  logic [31:0]        in_order_id,
  input  logic [1:0]         in_side,
  input  logic signed [31:0] in_price,
  input  logic [31:0]        in_quantity,
  input  logic [63:0]        in_timestamp,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_kind,
  output logic [3:0]         out_status,
  output logic [63:0]        out_seq,
  output logic [15:0]        out_symbol,
  output logic [63:0]        out_trade_number,
  output logic [31:0]        out_aggressor_id,
  output logic [31:0]        out_resting_id,
  output logic signed [31:0] out_trade_price,
  output logic [31:0]        out_amount,
  output logic [63:0]        out_trade_time,
  output logic               out_last
);
  import obm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  obm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  obm_dp #(.MAX_ORDERS(MAX_ORDERS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_symbol_code  (cfg_symbol_code),
    .in_req_type      (in_req_type),
    .in_symbol        (in_symbol),
    .in_event_seq     (in_event_seq),
    .in_order_id      (in_order_id),
    .in_side          (in_side),
    .in_price         (in_price),
    .in_quantity      (in_quantity),
    .in_timestamp     (in_timestamp),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_status       (out_status),
    .out_seq          (out_seq),
    .out_symbol       (out_symbol),
    .out_trade_number (out_trade_number),
    .out_aggressor_id (out_aggressor_id),
    .out_resting_id   (out_resting_id),
    .out_trade_price  (out_trade_price),
    .out_amount       (out_amount),
    .out_trade_time   (out_trade_time),
    .out_last         (out_last),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule

@@ dv/limit_order_book_matcher_tb.sv @@
// ----------------------------------------------------------------------------
// limit_order_book_matcher_tb
// Drives add, cancel, modify, execute and malformed requests into the matcher,
// tracks its own copy of the order book to predict every trade and status,
// and checks each result field by field under random idling on both sides.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import obm_pkg::*;

  localparam int BOOK_DEPTH = 32;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [15:0]        symbol;
    logic [63:0]        seq;
    logic [31:0]        id;
    logic [1:0]         side;
    logic signed [31:0] price;
    logic [31:0]        qty;
    logic [63:0]        stamp;
  } request_t;

  typedef struct packed {
    logic               kind;
    logic [3:0]         status;
    logic [63:0]        seq;
    logic [15:0]        symbol;
    logic [63:0]        trade_number;
    logic [31:0]        aggressor_id;
    logic [31:0]        passive_id;
    logic signed [31:0] trade_price;
    logic [31:0]        amount;
    logic [63:0]        trade_time;
    logic               last;
  } result_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [15:0] cfg_symbol_code;
  logic in_valid, in_stall;
  logic [2:0] in_req_type;
  logic [15:0] in_symbol;
  logic [63:0] in_event_seq;
  logic [31:0] in_order_id;
  logic [1:0] in_side;
  logic signed [31:0] in_price;
  logic [31:0] in_quantity;
  logic [63:0] in_timestamp;
  logic out_valid, out_stall;
  logic out_kind;
  logic [3:0] out_status;
  logic [63:0] out_seq;
  logic [15:0] out_symbol;
  logic [63:0] out_trade_number;
  logic [31:0] out_aggressor_id;
  logic [31:0] out_resting_id;
  logic signed [31:0] out_trade_price;
  logic [31:0] out_amount;
  logic [63:0] out_trade_time;
  logic out_last;

  limit_order_book_matcher #(.MAX_ORDERS(BOOK_DEPTH)) uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_symbol_code(cfg_symbol_code),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .in_symbol(in_symbol), .in_event_seq(in_event_seq),
    .in_order_id(in_order_id), .in_side(in_side), .in_price(in_price),
    .in_quantity(in_quantity), .in_timestamp(in_timestamp),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_kind(out_kind), .out_status(out_status), .out_seq(out_seq),
    .out_symbol(out_symbol), .out_trade_number(out_trade_number),
    .out_aggressor_id(out_aggressor_id), .out_resting_id(out_resting_id),
    .out_trade_price(out_trade_price), .out_amount(out_amount),
    .out_trade_time(out_trade_time), .out_last(out_last)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // book copy kept by the checker
  bit                 slot_used[BOOK_DEPTH];
  bit [31:0]          slot_id[BOOK_DEPTH];
  bit                 slot_side[BOOK_DEPTH];
  bit signed [31:0]   slot_price[BOOK_DEPTH];
  bit [31:0]          slot_qty[BOOK_DEPTH];
  bit [31:0]          slot_rank[BOOK_DEPTH];
  bit [31:0]          arrivals;
  bit [63:0]          next_trade;
  bit [15:0]          book_symbol;

  request_t pending_requests[$];
  result_t  due_results[$];
  int  accepted_requests;
  int  mismatches;
  bit  in_taken;
  bit  failed;

  function automatic void enqueue(request_t r);
    pending_requests.insert(pending_requests.size(), r);
  endfunction

  function automatic void add_due(result_t x);
    due_results.insert(due_results.size(), x);
  endfunction

  function automatic int lookup_slot(bit [31:0] id);
    for (int i = 0; i < BOOK_DEPTH; i++)
      if (slot_used[i] && slot_id[i] == id) return i;
    return -1;
  endfunction

  function automatic bit level_overflow(bit side, bit signed [31:0] price, bit [31:0] qty,
                                        bit [31:0] removed);
    longint unsigned sum;
    sum = 0;
    for (int i = 0; i < BOOK_DEPTH; i++)
      if (slot_used[i] && slot_side[i] == side && slot_price[i] == price)
        sum += slot_qty[i];
    sum = (sum >= removed) ? sum - removed : 0;
    return (longint'(qty) + sum) > 64'hFFFF_FFFF;
  endfunction

  function automatic int best_opposite(bit side);
    int best;
    bit better;
    best = -1;
    for (int i = 0; i < BOOK_DEPTH; i++) begin
      if (!slot_used[i] || slot_side[i] == side) continue;
      if (best < 0) better = 1;
      else if (slot_price[i] != slot_price[best])
        better = side ? (slot_price[i] > slot_price[best]) : (slot_price[i] < slot_price[best]);
      else
        better = (arrivals - slot_rank[i]) > (arrivals - slot_rank[best]);
      if (better) best = i;
    end
    return best;
  endfunction

  function automatic void push_status(logic [3:0] st, request_t r, logic [31:0] amt);
    result_t s;
    s = '0;
    s.kind = 1'b1;
    s.status = st;
    s.seq = r.seq;
    s.symbol = r.symbol;
    s.amount = amt;
    s.last = 1'b1;
    add_due(s);
  endfunction

  function automatic void submit_order(logic [1:0] side, request_t r);
    bit [31:0] qty;
    int b, slot;
    result_t t;
    qty = r.qty;
    if (side > 2'd1) begin push_status(ST_BAD_SIDE, r, 0); return; end
    if (qty == 0) begin push_status(ST_BAD_QTY, r, 0); return; end
    if (r.price <= 0) begin push_status(ST_BAD_PRC, r, 0); return; end
    if (lookup_slot(r.id) >= 0) begin push_status(ST_DUP, r, 0); return; end
    if (level_overflow(side[0], r.price, qty, 0)) begin
      push_status(ST_OVERFLOW, r, 0);
      return;
    end
    while (qty > 0) begin
      b = best_opposite(side[0]);
      if (b < 0) break;
      if (side[0] ? (r.price > slot_price[b]) : (r.price < slot_price[b])) break;
      t = '0;
      t.seq = r.seq;
      t.symbol = r.symbol;
      t.trade_number = next_trade;
      t.aggressor_id = r.id;
      t.passive_id = slot_id[b];
      t.trade_price = slot_price[b];
      t.amount = (qty < slot_qty[b]) ? qty : slot_qty[b];
      t.trade_time = r.stamp;
      add_due(t);
      next_trade++;
      qty -= t.amount;
      slot_qty[b] -= t.amount;
      if (slot_qty[b] == 0) slot_used[b] = 0;
    end
    if (qty == 0) begin push_status(ST_OK, r, 0); return; end
    slot = -1;
    for (int i = 0; i < BOOK_DEPTH; i++)
      if (!slot_used[i]) begin slot = i; break; end
    if (slot < 0) begin push_status(ST_FULL, r, 0); return; end
    slot_used[slot] = 1;
    slot_id[slot] = r.id;
    slot_side[slot] = side[0];
    slot_price[slot] = r.price;
    slot_qty[slot] = qty;
    slot_rank[slot] = arrivals;
    arrivals++;
    push_status(ST_OK, r, qty);
  endfunction

  function automatic void match_request(request_t r);
    int k;
    if (r.symbol != book_symbol) begin push_status(ST_SYMBOL, r, 0); return; end
    case (r.req_type)
      REQ_ADD: begin
        submit_order(r.side, r);
      end
      REQ_CANCEL: begin
        k = lookup_slot(r.id);
        if (k < 0) push_status(ST_UNKNOWN, r, 0);
        else begin
          slot_used[k] = 0;
          push_status(ST_OK, r, 0);
        end
      end
      REQ_MODIFY: begin
        k = lookup_slot(r.id);
        if (k < 0) push_status(ST_UNKNOWN, r, 0);
        else if (r.price <= 0) push_status(ST_BAD_PRC, r, 0);
        else if (r.qty == 0) push_status(ST_BAD_QTY, r, 0);
        else if (level_overflow(slot_side[k], r.price, r.qty,
                                r.price == slot_price[k] ? slot_qty[k] : 0))
          push_status(ST_OVERFLOW, r, 0);
        else if (r.price == slot_price[k] && r.qty <= slot_qty[k]) begin
          slot_qty[k] = r.qty;
          push_status(ST_OK, r, r.qty);
        end else begin
          slot_used[k] = 0;
          submit_order({1'b0, slot_side[k]}, r);
        end
      end
      REQ_EXECUTE: begin
        k = lookup_slot(r.id);
        if (k < 0) push_status(ST_UNKNOWN, r, 0);
        else if (r.qty == 0) push_status(ST_BAD_QTY, r, 0);
        else if (r.qty > slot_qty[k]) push_status(ST_EXCEEDS, r, 0);
        else begin
          slot_qty[k] -= r.qty;
          if (slot_qty[k] == 0) slot_used[k] = 0;
          push_status(ST_OK, r, slot_qty[k]);
        end
      end
      default: push_status(ST_UNSUPP, r, 0);
    endcase
  endfunction

  function automatic request_t order_request(logic [2:0] rt, logic [15:0] sym, logic [31:0] id,
                                             int side, logic signed [31:0] price,
                                             logic [31:0] qty);
    request_t r;
    r.req_type = rt;
    r.symbol = sym;
    r.seq = {$urandom, $urandom};
    r.id = id;
    r.side = 2'(side);
    r.price = price;
    r.qty = qty;
    r.stamp = {$urandom, $urandom};
    return r;
  endfunction

  // mostly well-formed traffic on a small id pool and a narrow price band
  function automatic request_t random_request(logic [15:0] sym);
    request_t r;
    int pick;
    logic [2:0] rt;
    logic [1:0] side;
    logic signed [31:0] price;
    logic [31:0] qty, id;
    pick = $urandom_range(99);
    rt = (pick < 50) ? REQ_ADD : (pick < 62) ? REQ_CANCEL :
         (pick < 80) ? REQ_MODIFY : (pick < 94) ? REQ_EXECUTE : 3'($urandom_range(4, 7));
    side = ($urandom_range(19) == 0) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(1));
    price = side[0] ? 32'($urandom_range(98, 110)) : 32'($urandom_range(92, 104));
    qty = 32'($urandom_range(1, 40));
    id = 32'($urandom_range(1, 60));
    case ($urandom_range(29))
      0: price = -$signed(32'($urandom_range(0, 32'h7FFF_FFFF)));
      1: price = 32'($urandom_range(1, 32'h7FFF_FFFF));
      2: qty = 0;
      3: qty = $urandom;
      4: id = $urandom;
      5: sym = 16'($urandom);
      default: ;
    endcase
    r = order_request(rt, sym, id, int'(side), price, qty);
    return r;
  endfunction

  task automatic write_symbol(logic [15:0] code);
    wait (pending_requests.size() == 0 && due_results.size() == 0 && !in_valid);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_symbol_code <= code;
    book_symbol = code;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(logic [15:0] sym, int count);
    for (int i = 0; i < count; i++) enqueue(random_request(sym));
  endtask

  // sender
  always @(negedge clk) begin
    request_t r;
    bit calm;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      calm = accepted_requests >= 200 && accepted_requests < 280;
      if (pending_requests.size() > 0 && (calm || $urandom_range(99) >= 21)) begin
        r = pending_requests.pop_front();
        in_valid <= 1'b1;
        in_req_type <= r.req_type;
        in_symbol <= r.symbol;
        in_event_seq <= r.seq;
        in_order_id <= r.id;
        in_side <= r.side;
        in_price <= r.price;
        in_quantity <= r.qty;
        in_timestamp <= r.stamp;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off to back the block up
  int  hold_left;
  bit  hold_done;
  always @(negedge clk) begin
    bit calm;
    calm = accepted_requests >= 200 && accepted_requests < 280;
    if (!hold_done && accepted_requests >= 120) begin
      hold_done = 1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 21);
    end
  end

  int idle_cycles;
  always @(posedge clk) begin
    request_t r;
    result_t got, want;
    bit any;
    in_taken = 0;
    any = 0;
    if (rst_n && in_valid && !in_stall) begin
      r = '{in_req_type, in_symbol, in_event_seq, in_order_id, in_side, in_price,
            in_quantity, in_timestamp};
      match_request(r);
      accepted_requests++;
      in_taken = 1;
      any = 1;
    end
    if (rst_n && out_valid && !out_stall) begin
      any = 1;
      got = '{out_kind, out_status, out_seq, out_symbol, out_trade_number, out_aggressor_id,
              out_resting_id, out_trade_price, out_amount, out_trade_time, out_last};
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result seq=%h status=%0d", got.seq, got.status);
      end else begin
        want = due_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch seq=%h", want.seq);
            $display("  exp kind=%0d st=%0d sym=%h tn=%0d ag=%h rs=%h px=%0d amt=%0d t=%h l=%0d",
                     want.kind, want.status, want.symbol, want.trade_number,
                     want.aggressor_id, want.passive_id, want.trade_price, want.amount,
                     want.trade_time, want.last);
            $display("  got kind=%0d st=%0d sym=%h tn=%0d ag=%h rs=%h px=%0d amt=%0d t=%h l=%0d",
                     got.kind, got.status, got.symbol, got.trade_number,
                     got.aggressor_id, got.passive_id, got.trade_price, got.amount,
                     got.trade_time, got.last);
          end
        end
      end
    end
    idle_cycles = any ? 0 : idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [15:0] s;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_symbol_code = '0;
    in_valid = 1'b0;
    in_req_type = '0;
    in_symbol = '0;
    in_event_seq = '0;
    in_order_id = '0;
    in_side = '0;
    in_price = '0;
    in_quantity = '0;
    in_timestamp = '0;
    out_stall = 1'b0;
    book_symbol = '0;
    arrivals = 0;
    next_trade = 1;
    foreach (slot_used[i]) slot_used[i] = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    s = 16'hFFFF;
    write_symbol(s);
    enqueue(order_request(REQ_ADD, s, 1, 0, 100, 10));
    enqueue(order_request(REQ_ADD, s, 2, 1, 101, 5));
    // crossing sell partly fills the resting buy
    enqueue(order_request(REQ_ADD, s, 3, 1, 100, 4));
    enqueue(order_request(REQ_ADD, s, 1, 0, 99, 1));
    enqueue(order_request(REQ_ADD, s, 6, 2, 99, 1));
    enqueue(order_request(REQ_ADD, s, 6, 3, 99, 1));
    enqueue(order_request(REQ_ADD, s, 6, 0, 99, 0));
    enqueue(order_request(REQ_ADD, s, 6, 0, 0, 1));
    enqueue(order_request(REQ_ADD, s, 6, 0, 32'sh8000_0000, 1));
    enqueue(order_request(REQ_ADD, s, 4, 1, 32'sh7FFF_FFFF, 32'hFFFF_FFFF));
    // level would exceed 32 bits
    enqueue(order_request(REQ_ADD, s, 5, 1, 32'sh7FFF_FFFF, 1));
    enqueue(order_request(REQ_MODIFY, s, 1, 3, 100, 3));
    enqueue(order_request(REQ_MODIFY, s, 1, 0, 100, 20));
    enqueue(order_request(REQ_MODIFY, s, 77, 0, 100, 1));
    enqueue(order_request(REQ_MODIFY, s, 1, 0, -1, 1));
    enqueue(order_request(REQ_MODIFY, s, 1, 0, 100, 0));
    enqueue(order_request(REQ_EXECUTE, s, 2, 0, 0, 2));
    enqueue(order_request(REQ_EXECUTE, s, 2, 0, 0, 9));
    enqueue(order_request(REQ_EXECUTE, s, 2, 0, 0, 0));
    enqueue(order_request(REQ_EXECUTE, s, 78, 0, 0, 1));
    // buy at the top price trades against both resting sell levels
    enqueue(order_request(REQ_ADD, s, 32'hFFFF_FFFF, 0, 32'sh7FFF_FFFF, 7));
    enqueue(order_request(REQ_CANCEL, s, 32'hFFFF_FFFF, 0, 0, 0));
    enqueue(order_request(REQ_CANCEL, s, 79, 0, 0, 0));
    enqueue(order_request(3'd4, s, 1, 0, 100, 1));
    enqueue(order_request(3'd7, s, 1, 0, 100, 1));
    enqueue(order_request(REQ_ADD, 16'h0000, 8, 0, 100, 1));

    write_symbol(16'h0000);
    random_phase(16'h0000, 150);
    s = 16'($urandom);
    write_symbol(s);
    random_phase(s, 150);
    write_symbol(16'hFFFF);
    random_phase(16'hFFFF, 100);

    wait (pending_requests.size() == 0 && due_results.size() == 0 && !in_valid);
    repeat (200) @(posedge clk);
    failed = mismatches != 0 || due_results.size() != 0;
    if (!failed) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
